// ===== rtl/aitsl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aitsl_pkg: shared types and constants of the aging id table speed limiter
// Request and response payloads, table entry layout, controller state and
// the command and status bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package aitsl_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;

  localparam logic [7:0] AGE_NEWEST = 8'd255;

  localparam logic [1:0] MODE_SAVE_REQ = 2'd0;
  localparam logic [1:0] MODE_SAVE_TRK = 2'd1;
  localparam logic [1:0] MODE_LOAD     = 2'd2;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] vehicle_id;
    logic [7:0] speed_value;
    logic       direction_in;
  } req_t;

  typedef struct packed {
    logic [7:0] limited_speed;
    logic       direction_out;
    logic       hit;
  } rsp_t;

  typedef struct packed {
    logic [7:0] id;
    logic [7:0] req_speed;
    logic [7:0] trk_limit;
    logic       dir;
    logic [7:0] age;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_VREAD,
    ST_VWRITE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic scan_start;
    logic scan_issue;
    logic victim_read;
    logic victim_write;
    logic pend_zero;
    logic out_push;
  } cmd_t;

  typedef struct packed {
    logic issue_done;
    logic ev_valid;
    logic ev_match;
    logic ev_last;
    logic is_load;
    logic out_free;
  } status_t;

  function automatic logic [7:0] min8(input logic [7:0] a, input logic [7:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

// ===== rtl/aitsl_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aitsl_ctrl: transaction sequencer
// Steps one request through lookup scan, then on a save miss victim read
// and write, and hands the finished response to the output register.
// ----------------------------------------------------------------------------
module aitsl_ctrl
  import aitsl_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.capture    = 1'b1;
          cmd.scan_start = 1'b1;
          state_next     = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        // stop issuing reads as soon as the match is seen
        cmd.scan_issue = !status.issue_done && !(status.ev_valid && status.ev_match);
        if (status.ev_valid && status.ev_match) begin
          state_next = ST_DONE;
        end else if (status.ev_valid && status.ev_last) begin
          if (status.is_load) begin
            cmd.pend_zero = 1'b1;
            state_next    = ST_DONE;
          end else begin
            state_next = ST_VREAD;
          end
        end
      end
      ST_VREAD: begin
        cmd.victim_read = 1'b1;
        state_next      = ST_VWRITE;
      end
      ST_VWRITE: begin
        cmd.victim_write = 1'b1;
        state_next       = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.out_push = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/aitsl_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aitsl_datapath: entry store, aging scan and victim selection
// Holds the table memory with per-entry valid bits, ages entries as they are
// scanned, tracks the replacement candidate and drives the output register.
// ----------------------------------------------------------------------------
module aitsl_datapath
  import aitsl_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)(
  input  logic    clk,
  input  logic    rst,
  input  cmd_t    cmd,
  output status_t status,
  input  req_t    req,
  output logic    rsp_valid,
  input  logic    rsp_ready,
  output rsp_t    rsp
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int SP_W  = $clog2(TABLE_ENTRIES + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [SP_W-1:0]  SP_RESET = SP_W'(TABLE_ENTRIES);

  entry_t                 mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid;

  req_t             in_q;
  logic [IDX_W-1:0] cnt;
  logic             issue_done;
  logic             rd_pend;
  logic [IDX_W-1:0] ev_idx;
  entry_t           rd_data;
  logic             vld_q;
  logic [SP_W-1:0]  sp;
  logic [7:0]       min_age;
  logic             any_vld;
  logic [IDX_W-1:0] any_idx;
  logic             aft_vld;
  logic [IDX_W-1:0] aft_idx;
  rsp_t             pend;
  rsp_t             out_q;
  logic             out_v;

  entry_t           ent_eff;
  entry_t           aged_ent;
  entry_t           hit_ent;
  entry_t           alloc_ent;
  logic             match;
  logic             past_sp;
  logic [IDX_W-1:0] victim;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  entry_t           mem_wd;
  logic             mem_re;
  logic [IDX_W-1:0] mem_ra;

  always_comb begin
    ent_eff = vld_q ? rd_data : '0;
    match   = (ent_eff.id == in_q.vehicle_id);
    past_sp = (SP_W'(ev_idx) > sp);
    victim  = aft_vld ? aft_idx : any_idx;

    aged_ent = ent_eff;
    if (ent_eff.age != 8'd0) begin
      aged_ent.age = ent_eff.age - 8'd1;
    end

    hit_ent     = ent_eff;
    hit_ent.age = AGE_NEWEST;
    if (in_q.mode == MODE_SAVE_REQ) begin
      hit_ent.req_speed = in_q.speed_value;
      hit_ent.dir       = in_q.direction_in;
    end else if (in_q.mode == MODE_SAVE_TRK) begin
      hit_ent.trk_limit = in_q.speed_value;
    end

    // the direction of a replaced entry survives a track limit save
    alloc_ent     = ent_eff;
    alloc_ent.id  = in_q.vehicle_id;
    alloc_ent.age = AGE_NEWEST;
    if (in_q.mode == MODE_SAVE_REQ) begin
      alloc_ent.req_speed = in_q.speed_value;
      alloc_ent.trk_limit = 8'd0;
      alloc_ent.dir       = in_q.direction_in;
    end else begin
      alloc_ent.req_speed = 8'd0;
      alloc_ent.trk_limit = in_q.speed_value;
    end

    mem_we = rd_pend || cmd.victim_write;
    mem_wa = cmd.victim_write ? victim : ev_idx;
    if (cmd.victim_write) begin
      mem_wd = alloc_ent;
    end else if (match) begin
      mem_wd = hit_ent;
    end else begin
      mem_wd = aged_ent;
    end

    mem_re = cmd.scan_issue || cmd.victim_read;
    mem_ra = cmd.victim_read ? victim : cnt;

    status.issue_done = issue_done;
    status.ev_valid   = rd_pend;
    status.ev_match   = match;
    status.ev_last    = (ev_idx == IDX_LAST);
    status.is_load    = (in_q.mode >= MODE_LOAD);
    status.out_free   = !out_v || rsp_ready;
  end

  // entry store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (mem_we) begin
      valid[mem_wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      vld_q <= valid[mem_ra];
    end
  end

  // scan sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      issue_done <= 1'b0;
      rd_pend    <= 1'b0;
      sp         <= SP_RESET;
      any_vld    <= 1'b0;
      aft_vld    <= 1'b0;
    end else begin
      rd_pend <= cmd.scan_issue;
      if (cmd.scan_start) begin
        cnt        <= '0;
        issue_done <= 1'b0;
        any_vld    <= 1'b0;
        aft_vld    <= 1'b0;
      end else if (cmd.scan_issue) begin
        if (cnt == IDX_LAST) begin
          issue_done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
      // track the lowest aged entry, first past the pointer and first overall
      if (rd_pend && !match) begin
        if (!any_vld || (aged_ent.age < min_age)) begin
          any_vld <= 1'b1;
          aft_vld <= past_sp;
        end else if ((aged_ent.age == min_age) && !aft_vld && past_sp) begin
          aft_vld <= 1'b1;
        end
      end
      if (cmd.victim_read) begin
        sp <= SP_W'(victim);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_issue) begin
      ev_idx <= cnt;
    end
    if (rd_pend && !match) begin
      if (!any_vld || (aged_ent.age < min_age)) begin
        min_age <= aged_ent.age;
        any_idx <= ev_idx;
        aft_idx <= ev_idx;
      end else if ((aged_ent.age == min_age) && !aft_vld && past_sp) begin
        aft_idx <= ev_idx;
      end
    end
  end

  // request capture and response staging
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_q <= req;
    end
    if (cmd.pend_zero) begin
      pend <= '0;
    end else if (cmd.victim_write) begin
      pend.limited_speed <= min8(alloc_ent.req_speed, alloc_ent.trk_limit);
      pend.direction_out <= alloc_ent.dir;
      pend.hit           <= 1'b0;
    end else if (rd_pend && match) begin
      pend.limited_speed <= min8(hit_ent.req_speed, hit_ent.trk_limit);
      pend.direction_out <= hit_ent.dir;
      pend.hit           <= 1'b1;
    end
    if (cmd.out_push) begin
      out_q <= pend;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (cmd.out_push) begin
      out_v <= 1'b1;
    end else if (rsp_ready) begin
      out_v <= 1'b0;
    end
  end

  assign rsp_valid = out_v;
  assign rsp       = out_q;

  a_push_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_push |-> (!out_v || rsp_ready))
    else $error("response pushed over a waiting transaction");

  a_victim_found: assert property (@(posedge clk) disable iff (rst)
    cmd.victim_read |-> any_vld)
    else $error("replacement search found no candidate");

  a_victim_order: assert property (@(posedge clk) disable iff (rst)
    cmd.victim_write |-> $past(cmd.victim_read))
    else $error("victim written without a prior read");

  a_sp_range: assert property (@(posedge clk) disable iff (rst)
    sp <= SP_RESET)
    else $error("scan pointer out of range");

endmodule

// ===== rtl/aging_id_table_speed_limiter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aging_id_table_speed_limiter_core: vehicle id table with aging and limiting
// Looks up a vehicle id, saves a requested speed or track limit, and answers
// with the smaller of the two stored speeds, or with zero on a load miss.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel takes one transaction (mode, vehicle_id, speed_value,
//   direction_in) at a time; req_ready is high only while the sequencer is
//   idle. Every request yields exactly one response on the rsp channel.
//   Each request runs at most one pass over the table, one entry per cycle:
//   the entry memory takes one registered read and one write-back a cycle.
//   A hit ends the pass early; a save miss adds a victim read and write
//   after it, a load miss does not. The next request is taken in the idle
//   state entered once the response is handed to the output register.
//   The response sits in an output register, so a stalled receiver does not
//   stop the next request from being looked up; only its final hand-over
//   waits until the earlier response has been taken.
//   Reset clears all valid bits at once, so every entry reads as id 0 with
//   zero speeds and age; the scan pointer returns to TABLE_ENTRIES.
// ----------------------------------------------------------------------------
module aging_id_table_speed_limiter_core
  import aitsl_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  // command and status bundles between sequencer and datapath
  cmd_t    cmd;
  status_t status;

  // sequencer: accept, scan, replace, hand over
  aitsl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: entry memory, aging, victim tracking, output register
  aitsl_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
